// ===== design/bse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Types, constants and fixed-point helpers for the escape-time evaluator.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int FxW = 48;
  localparam int MagW = 47;
  localparam int ItW = 16;
  localparam int PixW = 10;
  localparam int CfgIdxW = 3;
  localparam int NumLanes = 4;
  localparam int LaneW = 12;
  localparam int DefImgWidth = 1024;
  localparam int DefImgHeight = 1024;

  localparam logic [FxW-1:0] FxMax = {1'b0, {(FxW-1){1'b1}}};
  localparam logic [FxW-1:0] FxMin = {1'b1, {(FxW-1){1'b0}}};
  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_COL = 3'd0,
    REG_ORIGIN_ROW = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_OFFSET_X   = 3'd4,
    REG_OFFSET_Y   = 3'd5,
    REG_MAX_ITER   = 3'd6,
    REG_ESC_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SQ,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_col;
    logic [PixW-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0] out_col;
    logic [PixW-1:0] out_row;
    logic            escaped;
    logic [ItW-1:0]  iter_count;
    logic [MagW-1:0] final_mag_sq;
  } out_word_t;

  // operands of one lane multiplier pass; control travels with the data
  typedef struct packed {
    logic            load;
    logic [FxW-1:0]  a;
    logic [FxW-1:0]  b;
  } mul_req_t;

  function automatic logic [FxW-1:0] sat_add(input logic [FxW-1:0] a,
                                             input logic [FxW-1:0] b);
    logic [FxW:0] s;
    s = {a[FxW-1], a} + {b[FxW-1], b};
    if (s[FxW] != s[FxW-1]) return s[FxW] ? FxMin : FxMax;
    return s[FxW-1:0];
  endfunction

  function automatic logic [FxW-1:0] sat_sub(input logic [FxW-1:0] a,
                                             input logic [FxW-1:0] b);
    logic [FxW:0] s;
    s = {a[FxW-1], a} - {b[FxW-1], b};
    if (s[FxW] != s[FxW-1]) return s[FxW] ? FxMin : FxMax;
    return s[FxW-1:0];
  endfunction

  function automatic logic [FxW-1:0] mag48(input logic [FxW-1:0] v);
    return v[FxW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [FxW-1:0] abs_sat(input logic [FxW-1:0] v);
    logic [FxW-1:0] m;
    m = mag48(v);
    return m[FxW-1] ? {1'b0, MagMax} : m;
  endfunction

endpackage
`default_nettype wire

// ===== design/burning_ship_escape_time.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// burning_ship_escape_time
// Burning Ship escape-time evaluator for one pixel at a time.
// ----------------------------------------------------------------------------
// Usage: hold start with a pixel word on in_word; the word is taken at the
// first rising edge with busy low. One result word appears on out_word for
// one cycle, marked by out_strobe; it cannot be held off. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write
// them only while the block is idle, which the block does not enforce itself;
// cfg_ready is always high. Mapping the pixel to c forms cx, then cy, each
// from a registered product of pixel offset and step. The squares and the
// cross product go through one shared four-cell chain multiplier, one operand
// pair at a time; the mapping has a multiplier of its own. The starting
// squares are x*x and y*y plus a check; each iteration needs x*y, x*x and y*y
// plus a check. Busy stays high through the strobe cycle. Pixels outside the
// image go straight to the done state, skipping the mapping and iterations.
// Reset returns the configuration registers to their defaults and the control
// to idle; no result is produced for a word in flight at reset.
// ----------------------------------------------------------------------------
module burning_ship_escape_time #(
  parameter int ImgWidth  = bse_pkg::DefImgWidth,
  parameter int ImgHeight = bse_pkg::DefImgHeight
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bse_pkg::in_word_t    in_word,
  output logic                      out_strobe,
  output bse_pkg::out_word_t        out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [bse_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bse_pkg::FxW-1:0] cfg_data
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    OP_CX, OP_CY, OP_XX, OP_YY, OP_XY
  } op_t;

  logic [PixW-1:0] org_col_r, org_row_r;
  logic [MagW-1:0] step_x_r, step_y_r, esc_r;
  logic [FxW-1:0]  off_x_r, off_y_r;
  logic [ItW-1:0]  max_it_r;

  state_t state_r, state_nxt;
  logic [PixW-1:0] col_r, row_r;
  logic [FxW-1:0]  cx_r, cy_r, x_r, y_r, x2_r, y2_r;
  logic [ItW-1:0]  it_r;
  logic [MagW-1:0] msq_r;
  logic            out_esc_r;
  logic [ItW-1:0]  out_it_r;
  logic [MagW-1:0] out_msq_r;
  logic [2:0]      op_r, op_nxt;
  logic            issued_r;
  mul_req_t        req;
  logic            mdone;
  logic [FxW-1:0]  mprod;
  logic            outside;
  logic            accept;
  logic            last_op;
  logic [FxW-1:0]  t_val, dcol, drow;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_col_r <= 10'd512;
      org_row_r <= 10'd512;
      step_x_r  <= 47'd4294967;
      step_y_r  <= 47'd2576980;
      off_x_r   <= '0;
      off_y_r   <= '0;
      max_it_r  <= 16'd256;
      esc_r     <= 47'd21990232555520;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_COL: org_col_r <= cfg_data[PixW-1:0];
        REG_ORIGIN_ROW: org_row_r <= cfg_data[PixW-1:0];
        REG_STEP_X:     step_x_r  <= cfg_data[MagW-1:0];
        REG_STEP_Y:     step_y_r  <= cfg_data[MagW-1:0];
        REG_OFFSET_X:   off_x_r   <= cfg_data;
        REG_OFFSET_Y:   off_y_r   <= cfg_data;
        REG_MAX_ITER:   max_it_r  <= cfg_data[ItW-1:0];
        REG_ESC_LIMIT:  esc_r     <= cfg_data[MagW-1:0];
        default: ;
      endcase
    end
  end

  assign outside = (32'(in_word.pixel_col) >= ImgWidth) ||
                   (32'(in_word.pixel_row) >= ImgHeight);
  assign dcol = FxW'($signed({1'b0, col_r}) - $signed({1'b0, org_col_r}));
  assign drow = FxW'($signed({1'b0, row_r}) - $signed({1'b0, org_row_r}));

  // 11-bit signed diff times 47-bit step fits in 58 bits; plain integer
  // product, clamped to the Q7.40 range
  logic [2*FxW-1:0] cmap_full;
  logic [FxW-1:0]   cmap_sat;
  logic [FxW-1:0]   map_a;
  logic [MagW-1:0]  map_b;
  logic [2*FxW-1:0] map_prod_r;
  assign map_a = (state_r == ST_MAP && op_r == 3'(OP_CX)) ? dcol : drow;
  assign map_b = (state_r == ST_MAP && op_r == 3'(OP_CX)) ? step_x_r : step_y_r;
  always_ff @(posedge clk) begin
    map_prod_r <= 96'($signed(map_a[PixW:0]) * $signed({1'b0, map_b}));
  end
  assign cmap_full = map_prod_r;
  always_comb begin
    if ($signed(cmap_full) > $signed({{FxW{1'b0}}, FxMax})) cmap_sat = FxMax;
    else if ($signed(cmap_full) < $signed({{FxW{1'b1}}, FxMin})) cmap_sat = FxMin;
    else cmap_sat = cmap_full[FxW-1:0];
  end

  assign t_val = sat_add(sat_sub(x2_r, y2_r), cx_r);

  always_comb begin
    req.load = 1'b0;
    req.a    = x_r;
    req.b    = x_r;
    if (state_r == ST_SQ && !issued_r) begin
      req.load = 1'b1;
      unique case (op_t'(op_r))
        OP_YY:   begin req.a = y_r; req.b = y_r; end
        OP_XY:   begin req.a = x_r; req.b = y_r; end
        default: begin req.a = x_r; req.b = x_r; end
      endcase
    end
  end

  bse_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .done (mdone),
    .prod (mprod)
  );

  assign last_op = (op_r == 3'(OP_YY));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE:  if (accept) begin
                  state_nxt = outside ? ST_DONE : ST_MAP; op_nxt = 3'(OP_CX);
                end
      ST_MAP:   if (op_r == 3'(OP_CY) && issued_r) begin
                  state_nxt = ST_SQ; op_nxt = 3'(OP_XX);
                end else if (issued_r) op_nxt = 3'(OP_CY);
      ST_SQ:    if (mdone) begin
                  if (last_op) state_nxt = ST_CHECK;
                  else op_nxt = (op_r == 3'(OP_XY)) ? 3'(OP_XX) : 3'(OP_YY);
                end
      ST_CHECK: if (it_r < max_it_r && msq_r < esc_r) begin
                  state_nxt = ST_SQ; op_nxt = 3'(OP_XY);
                end else state_nxt = ST_DONE;
      ST_STEP:  state_nxt = ST_SQ;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= 3'(OP_CX);
      issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (state_r != state_nxt || op_r != op_nxt || mdone) issued_r <= 1'b0;
      else if (state_r == ST_SQ || state_r == ST_MAP) issued_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) begin
        col_r <= in_word.pixel_col;
        row_r <= in_word.pixel_row;
        it_r  <= '0;
        msq_r <= '0;
        out_esc_r <= 1'b0;
        out_it_r  <= '0;
        out_msq_r <= '0;
      end
      ST_MAP: if (issued_r) begin
        if (op_r == 3'(OP_CX)) begin
          cx_r <= sat_sub(cmap_sat, off_x_r);
          x_r  <= sat_sub(cmap_sat, off_x_r);
        end else begin
          cy_r <= sat_add(cmap_sat, off_y_r);
          y_r  <= sat_add(cmap_sat, off_y_r);
        end
      end
      ST_SQ: if (mdone) begin
        unique case (op_t'(op_r))
          OP_XX:   x2_r <= mprod;
          OP_YY:   begin
                     y2_r  <= mprod;
                     msq_r <= ({1'b0, x2_r[MagW-1:0]} + {1'b0, mprod[MagW-1:0]} > {1'b0, MagMax})
                              ? MagMax : MagW'(x2_r[MagW-1:0] + mprod[MagW-1:0]);
                   end
          OP_XY:   begin
                     x_r  <= abs_sat(t_val);
                     y_r  <= sat_add(sat_add(abs_sat(mprod), abs_sat(mprod)), cy_r);
                     it_r <= it_r + 1'b1;
                   end
          default: ;
        endcase
      end
      ST_CHECK: if (!(it_r < max_it_r && msq_r < esc_r)) begin
        out_esc_r <= (it_r < max_it_r);
        out_it_r  <= it_r;
        out_msq_r <= msq_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= (state_r == ST_DONE);
  end

  always_comb begin
    out_word.out_col      = col_r;
    out_word.out_row      = row_r;
    out_word.escaped      = out_esc_r;
    out_word.iter_count   = out_it_r;
    out_word.final_mag_sq = out_msq_r;
  end

  assign busy = (state_r != ST_IDLE) || out_strobe;
endmodule
`default_nettype wire

// ===== design/bse_mul_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_mul_cell
// One cell of the serial multiplier chain: 48 x 12 partial product, added to
// the running sum handed on by the previous cell.
// ----------------------------------------------------------------------------
module bse_mul_cell (
  input  wire logic                   clk,
  input  wire logic [bse_pkg::FxW-1:0] a_in,
  input  wire logic [bse_pkg::LaneW-1:0] b_lane,
  input  wire logic [bse_pkg::FxW+bse_pkg::FxW-1:0] acc_in,
  input  wire logic [5:0]             shift,
  output logic [bse_pkg::FxW-1:0]     a_out,
  output logic [bse_pkg::FxW+bse_pkg::FxW-1:0] acc_out
);
  import bse_pkg::*;

  logic [FxW+LaneW-1:0] pp;
  logic [2*FxW-1:0]     acc_r;
  logic [FxW-1:0]       a_r;

  assign pp = a_in * b_lane;

  always_ff @(posedge clk) begin
    a_r   <= a_in;
    acc_r <= acc_in + ({{(FxW-LaneW){1'b0}}, pp} << shift);
  end

  assign a_out   = a_r;
  assign acc_out = acc_r;
endmodule
`default_nettype wire

// ===== design/bse_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_mul
// Magnitude multiplier: a chain of four cells, one 12-bit digit of b each.
// Products are registered through the cells; Q40 truncation, clamp and sign on exit.
// ----------------------------------------------------------------------------
module bse_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bse_pkg::mul_req_t req,
  output logic                   done,
  output logic [bse_pkg::FxW-1:0] prod
);
  import bse_pkg::*;

  logic [FxW-1:0]   a_chain [NumLanes+1];
  logic [2*FxW-1:0] acc_chain [NumLanes+1];
  logic [FxW-1:0]   b_mag [NumLanes];
  logic [FxW-1:0]   b_r [NumLanes-1];
  logic             neg_r [NumLanes+1];
  logic [NumLanes-1:0] vld_r;
  logic [2*FxW-1:0] q;

  assign a_chain[0]   = mag48(req.a);
  assign acc_chain[0] = '0;
  assign b_mag[0]     = mag48(req.b);
  assign neg_r[0]     = req.a[FxW-1] ^ req.b[FxW-1];

  for (genvar i = 0; i < NumLanes; i++) begin : g_cell
    if (i > 0) begin : g_b
      assign b_mag[i] = b_r[i-1];
    end
    if (i < NumLanes-1) begin : g_breg
      always_ff @(posedge clk) begin
        b_r[i] <= b_mag[i];
      end
    end
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
    end
    bse_mul_cell u_cell (
      .clk    (clk),
      .a_in   (a_chain[i]),
      .b_lane (b_mag[i][i*LaneW +: LaneW]),
      .acc_in (acc_chain[i]),
      .shift  (6'(i*LaneW)),
      .a_out  (a_chain[i+1]),
      .acc_out(acc_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NumLanes-2:0], req.load};
  end

  always_comb begin
    q = acc_chain[NumLanes] >> 40;
    if (q > {{(2*FxW-MagW){1'b0}}, MagMax}) q = {{(2*FxW-MagW){1'b0}}, MagMax};
    prod = neg_r[NumLanes] ? (~q[FxW-1:0] + 1'b1) : q[FxW-1:0];
  end

  assign done = vld_r[NumLanes-1];
endmodule
`default_nettype wire

// ===== design/bse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks for the escape-time evaluator.
// ----------------------------------------------------------------------------
module bse_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe repeated");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without word");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_strobe) else $error("strobe after reset");
endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Escape-time evaluator testbench: pixel words are driven through the start/busy
// handshake across a series of view and cap settings. A scoreboard predicts each
// iteration count, escape flag and final squared magnitude in saturating Q7.40
// and compares every strobed result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bse_pkg::*;

  localparam longint FX_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FX_LO = -FX_HI - 1;
  localparam int CYCLE_LIMIT = 4000000;

  class escape_scoreboard;
    logic [9:0]  org_col, org_row;
    logic [46:0] step_x, step_y, esc_limit;
    longint      off_x, off_y;
    logic [15:0] iter_cap;
    out_word_t   pending_q[$];
    int          errors;

    function new();
      org_col = 10'd512; org_row = 10'd512;
      step_x = 47'd4294967; step_y = 47'd2576980;
      off_x = 0; off_y = 0;
      iter_cap = 16'd256;
      esc_limit = 47'd21990232555520;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [47:0] v);
      case (idx)
        REG_ORIGIN_COL: org_col = v[9:0];
        REG_ORIGIN_ROW: org_row = v[9:0];
        REG_STEP_X:     step_x = v[46:0];
        REG_STEP_Y:     step_y = v[46:0];
        REG_OFFSET_X:   off_x = longint'(signed'(v));
        REG_OFFSET_Y:   off_y = longint'(signed'(v));
        REG_MAX_ITER:   iter_cap = v[15:0];
        REG_ESC_LIMIT:  esc_limit = v[46:0];
        default: ;
      endcase
    endfunction

    static function longint clamp(longint v);
      if (v > FX_HI) return FX_HI;
      if (v < FX_LO) return FX_LO;
      return v;
    endfunction

    static function longint mag_sat(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      return (m > FX_HI) ? FX_HI : m;
    endfunction

    // magnitudes multiplied exactly, truncated, capped, sign applied last
    static function longint fx_mul(longint a, longint b);
      logic [47:0] ma, mb;
      logic [95:0] p;
      longint m;
      ma = (a < 0) ? 48'(-a) : 48'(a);
      mb = (b < 0) ? 48'(-b) : 48'(b);
      p = ma * mb;
      p = p >> 40;
      m = (p > 96'(FX_HI)) ? FX_HI : longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function out_word_t escape_result(in_word_t w);
      longint cx, cy, x, y, x2, y2, t, msq;
      int unsigned it;
      out_word_t r;
      r.out_col = w.pixel_col;
      r.out_row = w.pixel_row;
      r.escaped = 1'b0;
      r.iter_count = '0;
      r.final_mag_sq = '0;
      if (int'(w.pixel_col) >= DefImgWidth || int'(w.pixel_row) >= DefImgHeight)
        return r;
      cx = clamp((longint'(w.pixel_col) - longint'(org_col)) * longint'(step_x));
      cx = clamp(cx - off_x);
      cy = clamp((longint'(w.pixel_row) - longint'(org_row)) * longint'(step_y));
      cy = clamp(cy + off_y);
      x = cx; y = cy;
      x2 = fx_mul(x, x); y2 = fx_mul(y, y);
      msq = x2 + y2;
      if (msq > FX_HI) msq = FX_HI;
      it = 0;
      while (it < iter_cap && msq < longint'(esc_limit)) begin
        t = clamp(x2 - y2 + cx);
        y = clamp(clamp(2 * mag_sat(fx_mul(x, y))) + cy);
        x = mag_sat(t);
        x2 = fx_mul(x, x); y2 = fx_mul(y, y);
        msq = x2 + y2;
        if (msq > FX_HI) msq = FX_HI;
        it++;
      end
      r.escaped = (it < iter_cap);
      r.iter_count = it[15:0];
      r.final_mag_sq = msq[46:0];
      return r;
    endfunction

    function void note_pixel(in_word_t w);
      pending_q.push_back(escape_result(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result word col=%0d row=%0d", got.out_col, got.out_row);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.out_col !== e.out_col) begin
        $error("out_col exp %0d got %0d", e.out_col, got.out_col); errors++;
      end
      if (got.out_row !== e.out_row) begin
        $error("out_row exp %0d got %0d", e.out_row, got.out_row); errors++;
      end
      if (got.escaped !== e.escaped) begin
        $error("escaped exp %0d got %0d", e.escaped, got.escaped); errors++;
      end
      if (got.iter_count !== e.iter_count) begin
        $error("iter_count exp %0d got %0d", e.iter_count, got.iter_count); errors++;
      end
      if (got.final_mag_sq !== e.final_mag_sq) begin
        $error("final_mag_sq exp %0h got %0h", e.final_mag_sq, got.final_mag_sq);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_strobe;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [FxW-1:0]     cfg_data;

  escape_scoreboard sb;
  bit  idle_on;
  int  cycles;

  burning_ship_escape_time uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_word(out_word);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [9:0] c, input logic [9:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_word.pixel_col = c;
    in_word.pixel_row = r;
    do @(posedge clk); while (busy);
    sb.note_pixel(in_word);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_view(input logic [9:0] oc, input logic [9:0] orow,
                          input logic [46:0] sx, input logic [46:0] sy,
                          input logic [47:0] ox, input logic [47:0] oy,
                          input logic [15:0] cap, input logic [46:0] lim);
    drain();
    write_reg(REG_ORIGIN_COL, 48'(oc));
    write_reg(REG_ORIGIN_ROW, 48'(orow));
    write_reg(REG_STEP_X, 48'(sx));
    write_reg(REG_STEP_Y, 48'(sy));
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_MAX_ITER, 48'(cap));
    write_reg(REG_ESC_LIMIT, 48'(lim));
  endtask

  function automatic logic [9:0] near_pick(logic [9:0] centre);
    int v;
    v = int'(centre) + $urandom_range(0, 200) - 100;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      else
        send_pixel(near_pick(sb.org_col), near_pick(sb.org_row));
    end
  endtask

  task automatic corners();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(sb.org_col, sb.org_row);
  endtask

  initial begin
    logic [46:0] rs, rl;
    logic [47:0] ro;
    sb = new();
    cycles = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_COL;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // defaults: tiny view round the origin, all points hit the cap
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);

    // view of about +-2, limit 20
    set_view(10'd512, 10'd512, 47'd4294967296, 47'd4294967296, 48'd0, 48'd0,
             16'd32, 47'd21990232555520);
    corners();
    send_pixel(10'd511, 10'd513);
    random_pixels(90);

    set_view(10'd512, 10'd512, 47'd4294967296, 47'd4294967296, 48'd0, 48'd0,
             16'd1, 47'd4398046511104);
    random_pixels(55);

    // zero limit, largest cap: immediate escape
    set_view(10'd0, 10'd1023, 47'd4294967296, 47'd2147483648, 48'd0, 48'd0,
             16'd65535, 47'd0);
    corners();
    random_pixels(35);

    // largest step and limit: off the origin pixel, saturated squares reach the limit and escape at once
    set_view(10'd512, 10'd512, {47{1'b1}}, {47{1'b1}}, 48'd0, 48'd0,
             16'd24, {47{1'b1}});
    corners();
    random_pixels(35);

    // extreme pan offsets
    set_view(10'd1023, 10'd0, 47'd1073741824, 47'd1073741824,
             48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 16'd20, 47'd21990232555520);
    corners();
    set_view(10'd0, 10'd1023, 47'd1073741824, 47'd1073741824,
             48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 16'd20, 47'd21990232555520);
    corners();
    random_pixels(30);

    // ship region, deeper cap
    set_view(10'd512, 10'd512, 47'd429496730, 47'd429496730,
             48'd1924145348608, -48'sd32985348833, 16'd64, 47'd4398046511104);
    random_pixels(75);
    drain();
    random_pixels(75);

    // random views
    for (int k = 0; k < 4; k++) begin
      rs = 47'({$urandom, $urandom}) & 47'h0000_3FFF_FFFF;
      rl = 47'({$urandom, $urandom});
      rl = rl >> $urandom_range(4, 46);
      ro = 48'({$urandom, $urandom});
      ro = 48'(signed'(ro) >>> $urandom_range(0, 47));
      set_view(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), rs,
               47'({$urandom, $urandom}) & 47'h0000_3FFF_FFFF, ro,
               48'({$urandom, $urandom}), 16'($urandom_range(1, 12)), rl);
      random_pixels(25);
    end

    // closing stretch without idling
    set_view(10'd512, 10'd512, 47'd4294967296, 47'd4294967296, 48'd0, 48'd0,
             16'd16, 47'd21990232555520);
    idle_on = 1'b0;
    random_pixels(80);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
